// ===== hdl/mfb_pkg.sv =====
// Shared types and constants for the monochrome frame buffer controller.
// Used by every module under hdl/; no dependencies of its own.
package mfb_pkg;

  // Frame RAM geometry
  localparam int RamWords = 65536;
  localparam int RamAw    = $clog2(RamWords);

  // Command queue between front and back
  localparam int FifoDepth = 2;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Stream word layout
  localparam int AddrW     = 23;
  localparam int DataW     = 16;
  localparam int InDataW   = 48;  // address, write_data, byte_mask, zero fill
  localparam int InUserW   = 3;   // opcode, is_write
  localparam int OutDataW  = 40;  // read_data, pixel_word, irq_asserted, zero fill
  localparam int OutUserW  = 2;   // hit
  localparam int JumperW   = 4;

  // Control word bits
  localparam int CtlPend    = 12;
  localparam int CtlIntEn   = 13;
  localparam int CtlCopyEn  = 14;
  localparam int CtlVidEn   = 15;
  localparam int CtlBaseLsb = 1;
  localparam int CtlBaseMsb = 6;

  // Last scanout word for each resolution
  localparam logic [RamAw-1:0] LastWord900  = RamAw'(64799);
  localparam logic [RamAw-1:0] LastWord1024 = RamAw'(65535);

  // Board decode of address bits 12:11 with bit 19 set
  localparam logic [1:0] SelCtl    = 2'b11;
  localparam logic [1:0] SelSerial = 2'b00;

  typedef enum logic [1:0] {
    OP_BUS    = 2'd0,
    OP_SNOOP  = 2'd1,
    OP_VBLANK = 2'd2,
    OP_SCAN   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_RAM    = 2'd1,
    HIT_CTL    = 2'd2,
    HIT_SERIAL = 2'd3
  } hit_e;

  typedef enum logic [0:0] {
    CFG_JUMPERS   = 1'b0,
    CFG_IRQ_WIRED = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_RAM_RD,
    CMD_RAM_WR,
    CMD_CTL_RD,
    CMD_CTL_WR,
    CMD_SERIAL,
    CMD_SNOOP,
    CMD_VBLANK,
    CMD_SCAN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [RamAw-1:0]       word_idx;
    logic [5:0]             window;   // system address bits 22..17
    logic [DataW-1:0]       wdata;
    logic [1:0]             mask;
  } cmd_t;

endpackage

// ===== hdl/mfb_front.sv =====
// Front end: accepts input words and classifies them into commands.
// Depends on mfb_pkg; feeds mfb_cmd_fifo.
module mfb_front (
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // tdata: address[22:0], write_data[38:23], byte_mask[40:39], zero fill
  input  logic [mfb_pkg::InDataW-1:0] s_axis_tdata_i,
  // tuser: opcode[1:0], is_write[2]
  input  logic [mfb_pkg::InUserW-1:0] s_axis_tuser_i,
  input  logic                      fifo_full_i,
  input  logic                      clearing_i,
  output logic                      push_o,
  output mfb_pkg::cmd_t             cmd_o
);
  import mfb_pkg::*;

  opcode_e          opcode;
  logic             is_write;
  logic [AddrW-1:0] addr;
  logic [1:0]       sel;

  assign opcode   = opcode_e'(s_axis_tuser_i[1:0]);
  assign is_write = s_axis_tuser_i[2];
  assign addr     = s_axis_tdata_i[AddrW-1:0];
  assign sel      = addr[12:11];

  // hold off while the RAM clear runs or the queue is full
  assign s_axis_tready_o = !fifo_full_i && !clearing_i;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

  // classify the word
  always_comb begin
    cmd_o.word_idx = addr[RamAw:1];
    cmd_o.window   = addr[22:17];
    cmd_o.wdata    = s_axis_tdata_i[AddrW+DataW-1:AddrW];
    cmd_o.mask     = s_axis_tdata_i[AddrW+DataW+1:AddrW+DataW];
    cmd_o.kind     = CMD_NONE;
    unique case (opcode)
      OP_BUS: begin
        if (!addr[19]) begin
          cmd_o.kind = is_write ? CMD_RAM_WR : CMD_RAM_RD;
        end else if (sel == SelCtl) begin
          cmd_o.kind = is_write ? CMD_CTL_WR : CMD_CTL_RD;
        end else if (sel == SelSerial) begin
          cmd_o.kind = CMD_SERIAL;
        end else begin
          cmd_o.kind = CMD_NONE;  // decode hole
        end
      end
      OP_SNOOP:  cmd_o.kind = CMD_SNOOP;
      OP_VBLANK: cmd_o.kind = CMD_VBLANK;
      OP_SCAN:   cmd_o.kind = CMD_SCAN;
      default:   cmd_o.kind = CMD_NONE;
    endcase
  end

endmodule

// ===== hdl/mfb_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on mfb_pkg for the command type and depth.
module mfb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfb_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output mfb_pkg::cmd_t cmd_o
);
  import mfb_pkg::*;

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entries carry payload only
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/mfb_back.sv =====
// Back end: frame RAM, control word, interrupt line, scan pointer and
// the output register. Depends on mfb_pkg; pops commands from mfb_cmd_fifo.
module mfb_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  mfb_pkg::cmd_t                    cmd_i,
  output logic                             pop_o,
  input  logic [mfb_pkg::JumperW-1:0]      jumpers_i,
  input  logic                             irq_wired_i,
  output logic                             clearing_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: read_data[15:0], pixel_word[31:16], irq_asserted[32], zero fill
  output logic [mfb_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic                             m_axis_tlast_o,   // frame_end
  // tuser: hit[1:0]
  output logic [mfb_pkg::OutUserW-1:0]     m_axis_tuser_o
);
  import mfb_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [RamAw-1:0] clr_cnt_q, clr_cnt_d;
  logic [DataW-1:0] ctl_q, ctl_d;
  logic             irq_q, irq_d;
  logic [RamAw-1:0] scan_q, scan_d;

  // pending response fields
  cmd_kind_e        rsp_kind_q, rsp_kind_d;
  logic [DataW-1:0] rsp_ctl_q, rsp_ctl_d;
  logic             rsp_fend_q, rsp_fend_d;
  logic             rsp_vid_q, rsp_vid_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_rdata_q, out_rdata_d;
  logic [DataW-1:0] out_pix_q, out_pix_d;
  logic             out_irq_q, out_irq_d;
  logic             out_fend_q, out_fend_d;
  hit_e             out_hit_q, out_hit_d;

  // frame RAM
  logic [DataW-1:0] ram_q [RamWords];
  logic [DataW-1:0] ram_rd_q;
  logic [RamAw-1:0] ram_idx;
  logic [DataW-1:0] ram_wdata;
  logic [1:0]       ram_be;
  logic             ram_re;

  logic             out_free;
  logic             snoop_hit;
  logic [RamAw-1:0] last_word;
  logic             at_last;

  assign clearing_o = (state_q == ST_CLEAR);
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign pop_o      = (state_q == ST_IDLE) && cmd_valid_i && out_free;

  assign snoop_hit  = ctl_q[CtlCopyEn] && (cmd_i.window == ctl_q[CtlBaseMsb:CtlBaseLsb]);
  assign last_word  = jumpers_i[0] ? LastWord1024 : LastWord900;
  assign at_last    = (scan_q == last_word);

  // RAM port control
  always_comb begin
    ram_idx   = cmd_i.word_idx;
    ram_wdata = cmd_i.wdata;
    ram_be    = 2'b00;
    ram_re    = 1'b0;
    if (state_q == ST_CLEAR) begin
      ram_idx   = clr_cnt_q;
      ram_wdata = '0;
      ram_be    = 2'b11;
    end else if (pop_o) begin
      case (cmd_i.kind)
        CMD_RAM_WR: ram_be = cmd_i.mask;
        CMD_SNOOP:  ram_be = snoop_hit ? cmd_i.mask : 2'b00;
        CMD_RAM_RD: ram_re = 1'b1;
        CMD_SCAN: begin
          ram_idx = scan_q;
          ram_re  = 1'b1;
        end
        default: ram_be = 2'b00;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_be[1]) begin
      ram_q[ram_idx][15:8] <= ram_wdata[15:8];
    end
    if (ram_be[0]) begin
      ram_q[ram_idx][7:0] <= ram_wdata[7:0];
    end
    if (ram_re) begin
      ram_rd_q <= ram_q[ram_idx];
    end
  end

  // sequencer: clear, issue, respond
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    ctl_d       = ctl_q;
    irq_d       = irq_q;
    scan_d      = scan_q;
    rsp_kind_d  = rsp_kind_q;
    rsp_ctl_d   = rsp_ctl_q;
    rsp_fend_d  = rsp_fend_q;
    rsp_vid_d   = rsp_vid_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_rdata_d = out_rdata_q;
    out_pix_d   = out_pix_q;
    out_irq_d   = out_irq_q;
    out_fend_d  = out_fend_q;
    out_hit_d   = out_hit_q;

    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == RamAw'(RamWords - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          state_d    = ST_RESP;
          rsp_kind_d = cmd_i.kind;
          rsp_ctl_d  = ctl_q | {4'b0, jumpers_i, 8'b0};
          rsp_fend_d = 1'b0;
          rsp_vid_d  = ctl_q[CtlVidEn];
          case (cmd_i.kind)
            CMD_CTL_WR: begin
              // drop the line when pending or enable gets cleared
              if (irq_wired_i && ctl_q[CtlIntEn] && ctl_q[CtlPend] &&
                  (!cmd_i.wdata[CtlPend] || !cmd_i.wdata[CtlIntEn])) begin
                irq_d = 1'b0;
              end
              ctl_d = cmd_i.wdata;
            end
            CMD_VBLANK: begin
              ctl_d[CtlPend] = 1'b1;
              if (!ctl_q[CtlPend] && ctl_q[CtlIntEn] && irq_wired_i) begin
                irq_d = 1'b1;
              end
              scan_d = '0;
            end
            CMD_SCAN: begin
              rsp_fend_d = at_last;
              scan_d     = at_last ? '0 : scan_q + 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RESP: begin
        // RAM read data is valid now
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_irq_d   = irq_q;
        out_fend_d  = rsp_fend_q;
        out_rdata_d = '0;
        out_pix_d   = '0;
        case (rsp_kind_q)
          CMD_RAM_RD: out_rdata_d = ram_rd_q;
          CMD_CTL_RD: out_rdata_d = rsp_ctl_q;
          CMD_SCAN:   out_pix_d   = rsp_vid_q ? ram_rd_q : '0;
          default:    out_rdata_d = '0;
        endcase
        case (rsp_kind_q)
          CMD_RAM_RD, CMD_RAM_WR: out_hit_d = HIT_RAM;
          CMD_CTL_RD, CMD_CTL_WR: out_hit_d = HIT_CTL;
          CMD_SERIAL:             out_hit_d = HIT_SERIAL;
          default:                out_hit_d = HIT_NONE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      ctl_q       <= '0;
      irq_q       <= 1'b0;
      scan_q      <= '0;
      rsp_kind_q  <= CMD_NONE;
      rsp_ctl_q   <= '0;
      rsp_fend_q  <= 1'b0;
      rsp_vid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_rdata_q <= '0;
      out_pix_q   <= '0;
      out_irq_q   <= 1'b0;
      out_fend_q  <= 1'b0;
      out_hit_q   <= HIT_NONE;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      ctl_q       <= ctl_d;
      irq_q       <= irq_d;
      scan_q      <= scan_d;
      rsp_kind_q  <= rsp_kind_d;
      rsp_ctl_q   <= rsp_ctl_d;
      rsp_fend_q  <= rsp_fend_d;
      rsp_vid_q   <= rsp_vid_d;
      out_valid_q <= out_valid_d;
      out_rdata_q <= out_rdata_d;
      out_pix_q   <= out_pix_d;
      out_irq_q   <= out_irq_d;
      out_fend_q  <= out_fend_d;
      out_hit_q   <= out_hit_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - 2*DataW - 1)'(0), out_irq_q, out_pix_q, out_rdata_q};
  assign m_axis_tlast_o  = out_fend_q;
  assign m_axis_tuser_o  = out_hit_q;

endmodule

// ===== hdl/mono_framebuffer_controller.sv =====
// Monochrome frame buffer controller: 64K-word frame RAM with bus decode,
// copy-mode snooping, vblank interrupt and scanout.
// Input stream (s_axis): one word per bus access, snooped write, vblank or
//   scanout fetch; opcode and is_write travel in tuser.
// Output stream (m_axis): exactly one word per input word, in order; hit in
//   tuser, frame_end on tlast, read_data/pixel_word/irq_asserted in tdata.
// Config channel (cfg_*): index 0 board jumpers, index 1 irq-wired jumper;
//   always ready; to be written only while the block is idle, which it does not enforce.
// Path: an accepted word is registered in the command queue, issued to the
//   frame RAM with its registered read, then loaded into the output register.
//   The back end takes a new command only after the last reached the output register.
// Reset: the frame RAM is cleared by a sweep over all 65536 words, one word a
//   cycle; s_axis_tready_o stays low until it finishes. Control word, irq,
//   scan pointer go to zero; jumpers to 0, irq-wired to 1.
// Stall: the output register holds its word while m_axis_tready_i is low;
//   the 2-entry command queue keeps accepting until it fills.
module mono_framebuffer_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: address[22:0], write_data[38:23], byte_mask[40:39], zero fill
  input  logic [mfb_pkg::InDataW-1:0]        s_axis_tdata_i,
  // tuser: opcode[1:0], is_write[2]
  input  logic [mfb_pkg::InUserW-1:0]        s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: read_data[15:0], pixel_word[31:16], irq_asserted[32], zero fill
  output logic [mfb_pkg::OutDataW-1:0]       m_axis_tdata_o,
  output logic                               m_axis_tlast_o,   // frame_end
  // tuser: hit[1:0]
  output logic [mfb_pkg::OutUserW-1:0]       m_axis_tuser_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [mfb_pkg::JumperW-1:0]        cfg_data_i
);
  import mfb_pkg::*;

  logic [JumperW-1:0] jumpers_q;
  logic               irq_wired_q;
  logic               push;
  logic               pop;
  logic               fifo_full;
  logic               fifo_valid;
  logic               clearing;
  cmd_t               front_cmd;
  cmd_t               head_cmd;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jumpers_q   <= '0;
      irq_wired_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_JUMPERS:   jumpers_q   <= cfg_data_i;
        CFG_IRQ_WIRED: irq_wired_q <= cfg_data_i[0];
        default:       jumpers_q   <= jumpers_q;
      endcase
    end
  end

  mfb_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .fifo_full_i     (fifo_full),
    .clearing_i      (clearing),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  mfb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  mfb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (fifo_valid),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .jumpers_i       (jumpers_q),
    .irq_wired_i     (irq_wired_q),
    .clearing_o      (clearing),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== tb/mfb_reply_checker.sv =====
// Output checker for the monochrome frame buffer controller: watches the input,
// output and register channels, predicts every output word and compares it.
// Depends on mfb_pkg for the stream layout, the codes and the control word bits.
module mfb_reply_checker import mfb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic [InUserW-1:0]  in_user_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutDataW-1:0] out_data_i,
  input  logic                out_last_i,
  input  logic [OutUserW-1:0] out_user_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_index_i,
  input  logic [JumperW-1:0]  cfg_data_i,
  output int                  errors_o,
  output int                  outstanding_o,
  output int                  checked_o,
  output int                  frame_ends_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 50;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    hit_e             hit;
    logic [DataW-1:0] pixel_word;
    logic             frame_end;
    logic             irq;
  } board_reply_t;

  // Predicted board state
  logic [DataW-1:0]   fb_ram [RamWords];
  logic [DataW-1:0]   ctl_word;
  logic               irq_line;
  logic [RamAw-1:0]   scan_ptr;
  logic [JumperW-1:0] jumpers;
  logic               irq_wired;

  board_reply_t replies_due[$];

  initial begin
    for (int i = 0; i < RamWords; i++) fb_ram[i] = '0;
    ctl_word  = '0;
    irq_line  = 1'b0;
    scan_ptr  = '0;
    jumpers   = '0;
    irq_wired = 1'b1;
  end

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    errors_o++;
    if (errors_o <= MaxReports)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
  endtask

  // Byte-masked update of one frame RAM word
  task automatic merge_ram(input logic [RamAw-1:0] idx, input logic [DataW-1:0] data,
                           input logic [1:0] mask);
    logic [DataW-1:0] keep;
    keep = {{8{mask[1]}}, {8{mask[0]}}};
    fb_ram[idx] = (fb_ram[idx] & ~keep) | (data & keep);
  endtask

  // Works out the reply word for one accepted input word and updates the state
  task automatic model_board_word(input opcode_e op, input logic wr,
                                  input logic [AddrW-1:0] addr,
                                  input logic [DataW-1:0] wdata, input logic [1:0] mask,
                                  output board_reply_t r);
    logic               was_pending;
    logic [RamAw-1:0]   last_word;
    r = '0;
    case (op)
      OP_BUS: begin
        if (!addr[19]) begin
          r.hit = HIT_RAM;
          if (wr) merge_ram(addr[RamAw:1], wdata, mask);
          else r.read_data = fb_ram[addr[RamAw:1]];
        end else if (addr[12:11] == SelCtl) begin
          r.hit = HIT_CTL;
          if (wr) begin
            // pending or enable cleared drops a raised line
            if (irq_wired && ctl_word[CtlIntEn] && ctl_word[CtlPend] &&
                (!wdata[CtlPend] || !wdata[CtlIntEn]))
              irq_line = 1'b0;
            ctl_word = wdata;
          end else begin
            r.read_data = ctl_word | {4'b0, jumpers, 8'b0};
          end
        end else if (addr[12:11] == SelSerial) begin
          r.hit = HIT_SERIAL;
        end
      end
      OP_SNOOP: begin
        if (ctl_word[CtlCopyEn] && addr[22:17] == ctl_word[CtlBaseMsb:CtlBaseLsb])
          merge_ram(addr[RamAw:1], wdata, mask);
      end
      OP_VBLANK: begin
        was_pending = ctl_word[CtlPend];
        ctl_word[CtlPend] = 1'b1;
        if (!was_pending && ctl_word[CtlIntEn] && irq_wired) irq_line = 1'b1;
        scan_ptr = '0;
      end
      default: begin
        last_word = jumpers[0] ? LastWord1024 : LastWord900;
        if (ctl_word[CtlVidEn]) r.pixel_word = fb_ram[scan_ptr];
        if (scan_ptr == last_word) begin
          r.frame_end = 1'b1;
          scan_ptr = '0;
        end else begin
          scan_ptr = scan_ptr + 1'b1;
        end
      end
    endcase
    r.irq = irq_line;
  endtask

  // Output words first, so a word never meets the expectation pushed on its own edge
  always @(posedge clk_i) begin
    board_reply_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("word with nothing due", out_data_i[31:0], '0);
        end else begin
          want = replies_due.pop_front();
          if (out_data_i[15:0] !== want.read_data)
            flag_mismatch("read_data", 32'(out_data_i[15:0]), 32'(want.read_data));
          if (out_user_i !== want.hit)
            flag_mismatch("hit", 32'(out_user_i), 32'(want.hit));
          if (out_data_i[31:16] !== want.pixel_word)
            flag_mismatch("pixel_word", 32'(out_data_i[31:16]), 32'(want.pixel_word));
          if (out_last_i !== want.frame_end)
            flag_mismatch("frame_end", 32'(out_last_i), 32'(want.frame_end));
          if (out_data_i[32] !== want.irq)
            flag_mismatch("irq_asserted", 32'(out_data_i[32]), 32'(want.irq));
          checked_o++;
          if (want.frame_end) frame_ends_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_idx_e'(cfg_index_i) == CFG_JUMPERS) jumpers = cfg_data_i;
        else irq_wired = cfg_data_i[0];
      end
      if (in_valid_i && in_ready_i) begin
        model_board_word(opcode_e'(in_user_i[1:0]), in_user_i[2],
                         in_data_i[AddrW-1:0], in_data_i[AddrW+DataW-1:AddrW],
                         in_data_i[AddrW+DataW+1:AddrW+DataW], want);
        replies_due.push_back(want);
      end
    end
    outstanding_o <= replies_due.size();
  end

endmodule

// ===== tb/mono_framebuffer_controller_test.sv =====
// Testbench top for the monochrome frame buffer controller: clock, reset,
// directed and random stimulus, idling phases and the final verdict.
// Depends on mfb_pkg, mono_framebuffer_controller and mfb_reply_checker.
module mono_framebuffer_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mfb_pkg::*;

  localparam int HoldCycles     = 300;
  localparam int DrainGap       = 8;
  localparam int RandomPerPhase = 460;
  localparam int TimeoutNs      = 20_000_000;

  localparam logic [AddrW-1:0] CtlAddr = 23'h081800;
  localparam logic [DataW-1:0] PendBit   = 16'(1) << CtlPend;
  localparam logic [DataW-1:0] IntEnBit  = 16'(1) << CtlIntEn;
  localparam logic [DataW-1:0] CopyEnBit = 16'(1) << CtlCopyEn;
  localparam logic [DataW-1:0] VidEnBit  = 16'(1) << CtlVidEn;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data = '0;
  logic [InUserW-1:0]  in_user = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;
  logic                out_last;
  logic [OutUserW-1:0] out_user;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CFG_JUMPERS;
  logic [JumperW-1:0]  cfg_data = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [7:0]  hold_seq = '0;
  logic [7:0]  hold_seen = '0;
  int          hold_left = 0;
  logic [5:0]  copy_window = '0;
  int          words_sent = 0;
  int          settings_run = 0;

  int errors, outstanding, checked, frame_ends;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mono_framebuffer_controller i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tlast_o  (out_last),
    .m_axis_tuser_o  (out_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  mfb_reply_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .in_user_i     (in_user),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .out_last_i    (out_last),
    .out_user_i    (out_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .frame_ends_o  (frame_ends)
  );

  // Receiver: random stalls, plus a long hold-off each time hold_seq moves
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one word after a random gap and wait for its handshake
  task automatic send_word(input opcode_e op, input logic wr, input logic [AddrW-1:0] addr,
                           input logic [DataW-1:0] wdata, input logic [1:0] mask);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {7'b0, mask, wdata, addr};
    in_user  <= {wr, op};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic write_control(input logic [DataW-1:0] value);
    send_word(OP_BUS, 1'b1, CtlAddr, value, 2'b11);
    copy_window = value[CtlBaseMsb:CtlBaseLsb];
  endtask

  task automatic send_scan();
    send_word(OP_SCAN, 1'($urandom), 23'($urandom), 16'($urandom), 2'($urandom));
  endtask

  // Stop offering and wait until every reply is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DrainGap) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [JumperW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random word: mostly a small pool of RAM words so reads and scans see writes
  task automatic send_random_word();
    int unsigned      pick;
    int unsigned      region;
    opcode_e          op;
    logic             wr;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
    logic [1:0]       mask;
    pick  = $urandom_range(99);
    wr    = 1'($urandom);
    addr  = 23'($urandom);
    wdata = 16'($urandom);
    mask  = 2'($urandom);
    if ($urandom_range(99) < 70) addr[RamAw:1] = 16'($urandom_range(63));
    if (pick < 45) begin
      op = OP_BUS;
      region = $urandom_range(9);
      if (region < 5) begin
        addr[19] = 1'b0;
      end else if (region < 7) begin
        addr[19] = 1'b1;
        addr[12:11] = SelCtl;
      end else if (region == 7) begin
        addr[19] = 1'b1;
        addr[12:11] = SelSerial;
      end else begin
        addr[19] = 1'b1;
      end
    end else if (pick < 65) begin
      op = OP_SNOOP;
      if ($urandom_range(99) < 60) addr[22:17] = copy_window;
    end else if (pick < 73) begin
      op = OP_VBLANK;
    end else begin
      op = OP_SCAN;
    end
    send_word(op, wr, addr, wdata, mask);
    if (op == OP_BUS && wr && addr[19] && addr[12:11] == SelCtl)
      copy_window = wdata[CtlBaseMsb:CtlBaseLsb];
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // RAM at both ends of the word range, each byte mask, high address bits ignored
    send_word(OP_BUS, 1'b1, 23'h000000, 16'hFFFF, 2'b11);
    send_word(OP_BUS, 1'b1, 23'h01FFFE, 16'hA5C3, 2'b10);
    send_word(OP_BUS, 1'b1, 23'h700003, 16'h1234, 2'b01);
    send_word(OP_BUS, 1'b1, 23'h000001, 16'h0000, 2'b00);
    send_word(OP_BUS, 1'b0, 23'h000001, 16'hFFFF, 2'b11);
    send_word(OP_BUS, 1'b0, 23'h77FFFF, 16'h0000, 2'b00);
    send_word(OP_BUS, 1'b0, 23'h000002, 16'h0000, 2'b00);
    // control read with all other address bits set
    send_word(OP_BUS, 1'b0, 23'h7FFFFF, 16'h0000, 2'b11);
    // enable with pending already set: line stays low
    write_control(PendBit | IntEnBit);
    send_word(OP_VBLANK, 1'b0, '0, '0, '0);
    write_control(IntEnBit);
    send_word(OP_VBLANK, 1'b0, '0, '0, '0);
    write_control(PendBit | IntEnBit);
    write_control(IntEnBit);
    send_word(OP_VBLANK, 1'b0, '0, '0, '0);
    write_control(PendBit);
    // decode holes and the serial controller
    send_word(OP_BUS, 1'b0, 23'h080800, 16'hFFFF, 2'b11);
    send_word(OP_BUS, 1'b1, 23'h081000, 16'hFFFF, 2'b11);
    send_word(OP_BUS, 1'b0, 23'h080000, 16'hFFFF, 2'b11);
    send_word(OP_BUS, 1'b1, 23'h0807FF, 16'hFFFF, 2'b11);
    // copy mode: matching window, other window, then copy disabled
    write_control(CopyEnBit | 16'h002A);
    send_word(OP_SNOOP, 1'b1, 23'h2A0004, 16'hBEEF, 2'b11);
    send_word(OP_SNOOP, 1'b1, 23'h2C0006, 16'h5555, 2'b11);
    write_control(VidEnBit | 16'h002A);
    send_word(OP_SNOOP, 1'b1, 23'h2A0006, 16'h7777, 2'b11);
    send_word(OP_BUS, 1'b0, 23'h000004, 16'h0000, 2'b00);
    // scanout with video on and off
    send_word(OP_VBLANK, 1'b0, '0, '0, '0);
    send_scan();
    send_scan();
    write_control(16'h0000);
    send_scan();

    // Random phases, each under its own register settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_JUMPERS, 4'hF);
          write_reg(CFG_IRQ_WIRED, 4'h0);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(CFG_JUMPERS, 4'h0);
          write_reg(CFG_IRQ_WIRED, 4'h1);
          idle_pct = 53;
          stall_pct = 0;
        end
        2: begin
          write_reg(CFG_JUMPERS, 4'($urandom));
          write_reg(CFG_IRQ_WIRED, 4'h1);
          idle_pct = 0;
          stall_pct = 53;
        end
        default: begin
          write_reg(CFG_JUMPERS, 4'($urandom));
          write_reg(CFG_IRQ_WIRED, 4'($urandom));
          idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      settings_run++;
      repeat (RandomPerPhase) send_random_word();
      // receiver holds off while the sender keeps offering: input must stall
      if (phase == 0) begin
        hold_seq <= hold_seq + 1'b1;
        repeat (40) send_random_word();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d input words under %0d register settings: %0d replies checked,",
             words_sent, settings_run, checked);
    $display("%0d frame ends, idle and stall phases, a long output hold-off.", frame_ends);
    if (errors == 0) begin
      $display("mono_framebuffer_controller_test: PASS");
    end else begin
      $display("mono_framebuffer_controller_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Timed out with %0d replies outstanding", outstanding);
    $display("mono_framebuffer_controller_test: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mfb_pkg.sv
hdl/mfb_front.sv
hdl/mfb_cmd_fifo.sv
hdl/mfb_back.sv
hdl/mono_framebuffer_controller.sv
tb/mfb_reply_checker.sv
tb/mono_framebuffer_controller_test.sv
